### rtl/core/acr_pkg.sv
// Package for the anti-aliased circle rasterizer: widths, register indexes,
// row descriptor and state types, and the octant point table.
// Depends on nothing; every file of the block refers to it by scoped names.
package acr_pkg;

	localparam int COORD_BITS     = 12;
	localparam int FRACTION_BITS  = 8;
	localparam int RAD_BITS       = COORD_BITS - 1;
	localparam int POS_BITS       = COORD_BITS;
	localparam int PIX_BITS       = COORD_BITS + 2;
	localparam int COLOR_BITS     = 8;
	localparam int WEIGHT_BITS    = FRACTION_BITS + 1;
	localparam int SQ_BITS        = 2 * RAD_BITS;
	localparam int RADICAND_BITS  = SQ_BITS + 2 * FRACTION_BITS;
	localparam int ROOT_BITS      = RADICAND_BITS / 2;
	localparam int REM_BITS       = ROOT_BITS + 2;
	localparam int ITER_BITS      = $clog2(ROOT_BITS + 1);
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = COORD_BITS;
	localparam int IN_DATA_BITS   = 8;
	localparam int PAYLOAD_BITS   = 2 * PIX_BITS + 3 * COLOR_BITS;
	localparam int OUT_DATA_BITS  = ((PAYLOAD_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_BITS   = OUT_DATA_BITS - PAYLOAD_BITS;
	localparam int POINTS         = 8;
	localparam int POINT_BITS     = 3;
	localparam int FIFO_DEPTH     = 2;
	localparam int FIFO_PTR_BITS  = 1;
	localparam int FIFO_CNT_BITS  = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_CENTRE_X,
		CFG_CENTRE_Y,
		CFG_RADIUS,
		CFG_COLOR_RED,
		CFG_COLOR_GREEN,
		CFG_COLOR_BLUE
	} cfg_index_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] centre_x;
		logic [COORD_BITS-1:0] centre_y;
		logic [RAD_BITS-1:0]   radius;
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
	} cfg_t;

	typedef struct packed {
		logic                       finished;
		logic signed [POS_BITS-1:0] x;
		logic [POS_BITS-1:0]        y;
		logic [FRACTION_BITS-1:0]   dc;
	} row_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_CHECK,
		FR_MUL,
		FR_SUB,
		FR_ROOT,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		NB_CENTRE,
		NB_INNER,
		NB_OUTER
	} nb_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic swap;
	} point_t;

	function automatic point_t point_lookup(input logic [POINT_BITS-1:0] k);
		point_t p;
		unique case (k)
			3'd0: p = '{neg_x: 1'b0, neg_y: 1'b0, swap: 1'b0};
			3'd1: p = '{neg_x: 1'b0, neg_y: 1'b0, swap: 1'b1};
			3'd2: p = '{neg_x: 1'b1, neg_y: 1'b0, swap: 1'b0};
			3'd3: p = '{neg_x: 1'b0, neg_y: 1'b1, swap: 1'b1};
			3'd4: p = '{neg_x: 1'b0, neg_y: 1'b1, swap: 1'b0};
			3'd5: p = '{neg_x: 1'b1, neg_y: 1'b0, swap: 1'b1};
			3'd6: p = '{neg_x: 1'b1, neg_y: 1'b1, swap: 1'b1};
			default: p = '{neg_x: 1'b1, neg_y: 1'b1, swap: 1'b0};
		endcase
		return p;
	endfunction

endpackage

### rtl/core/acr_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Also reports whether the radicand was a perfect square. Uses acr_pkg.
module acr_sqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [acr_pkg::RADICAND_BITS-1:0]   radicand,
	output logic                                done,
	output logic [acr_pkg::ROOT_BITS-1:0]       root,
	output logic                                exact
);

	logic                              busy_q;
	logic                              done_q;
	logic [acr_pkg::ITER_BITS-1:0]     cnt_q;
	logic [acr_pkg::RADICAND_BITS-1:0] rad_q;
	logic [acr_pkg::REM_BITS-1:0]      rem_q;
	logic [acr_pkg::ROOT_BITS-1:0]     root_q;
	logic [acr_pkg::REM_BITS+1:0]      cand;
	logic [acr_pkg::REM_BITS+1:0]      trial;
	logic [acr_pkg::REM_BITS+1:0]      diff;
	logic                              ge;

	always_comb begin
		cand  = {rem_q, rad_q[acr_pkg::RADICAND_BITS-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = cand >= trial;
		diff  = cand - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= acr_pkg::ITER_BITS'(acr_pkg::ROOT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - acr_pkg::ITER_BITS'(1);
			if (cnt_q == acr_pkg::ITER_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? diff[acr_pkg::REM_BITS-1:0] : cand[acr_pkg::REM_BITS-1:0];
			root_q <= {root_q[acr_pkg::ROOT_BITS-2:0], ge};
		end
	end

	assign done  = done_q;
	assign root  = root_q;
	assign exact = (rem_q == '0);

endmodule

### rtl/core/acr_front.sv
// Front part: accepts requests, keeps the octant position and works out
// each row's ceiling distance with acr_sqrt. Uses acr_pkg.
module acr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	input  logic [acr_pkg::RAD_BITS-1:0]  radius,
	output logic                          push,
	output acr_pkg::row_t                 push_row,
	input  logic                          full
);

	acr_pkg::front_state_t state_q, state_d;

	logic signed [acr_pkg::POS_BITS-1:0]   x_q;
	logic [acr_pkg::POS_BITS-1:0]          y_q;
	logic [acr_pkg::FRACTION_BITS-1:0]     pd_q;
	logic                                  run_q;
	logic [acr_pkg::SQ_BITS-1:0]           rr_q;
	logic [2*acr_pkg::POS_BITS-1:0]        yy_q;
	logic                                  gt_q;
	acr_pkg::row_t                         row_q;

	logic                                  sq_start;
	logic                                  sq_done;
	logic [acr_pkg::ROOT_BITS-1:0]         sq_root;
	logic                                  sq_exact;
	logic [2*acr_pkg::POS_BITS-1:0]        v_full;
	logic [acr_pkg::RADICAND_BITS-1:0]     radicand;
	logic                                  octant_done;
	logic [acr_pkg::FRACTION_BITS-1:0]     dc;
	logic signed [acr_pkg::POS_BITS-1:0]   x_next;

	always_comb begin
		v_full      = {{(2*acr_pkg::POS_BITS-acr_pkg::SQ_BITS){1'b0}}, rr_q} - yy_q;
		radicand    = {v_full[acr_pkg::SQ_BITS-1:0], {(2*acr_pkg::FRACTION_BITS){1'b0}}};
		octant_done = !run_q || ($signed({x_q[acr_pkg::POS_BITS-1], x_q}) <
			$signed({1'b0, y_q}));
		dc          = (gt_q || sq_exact) ? '0 : ~sq_root[acr_pkg::FRACTION_BITS-1:0];
		x_next      = (dc <= pd_q) ? x_q - acr_pkg::POS_BITS'(1) : x_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			acr_pkg::FR_IDLE:  if (in_valid) state_d = acr_pkg::FR_CHECK;
			acr_pkg::FR_CHECK: state_d = octant_done ? acr_pkg::FR_PUSH : acr_pkg::FR_MUL;
			acr_pkg::FR_MUL:   state_d = acr_pkg::FR_SUB;
			acr_pkg::FR_SUB:   state_d = acr_pkg::FR_ROOT;
			acr_pkg::FR_ROOT:  if (sq_done) state_d = acr_pkg::FR_PUSH;
			acr_pkg::FR_PUSH:  if (!full) state_d = acr_pkg::FR_IDLE;
			default:           state_d = acr_pkg::FR_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == acr_pkg::FR_IDLE);
		sq_start = (state_q == acr_pkg::FR_SUB);
		push     = (state_q == acr_pkg::FR_PUSH) && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acr_pkg::FR_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			pd_q    <= '0;
			run_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == acr_pkg::FR_IDLE && in_valid && restart) begin
				x_q   <= $signed({1'b0, radius});
				y_q   <= '0;
				pd_q  <= '0;
				run_q <= 1'b1;
			end
			if (state_q == acr_pkg::FR_CHECK && octant_done) begin
				run_q <= 1'b0;
			end
			if (state_q == acr_pkg::FR_ROOT && sq_done) begin
				x_q  <= x_next;
				pd_q <= dc;
				y_q  <= y_q + acr_pkg::POS_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == acr_pkg::FR_MUL) begin
			rr_q <= radius * radius;
			yy_q <= y_q * y_q;
			gt_q <= {1'b0, radius} < y_q;
		end
		if (state_q == acr_pkg::FR_CHECK && octant_done) begin
			row_q <= '{finished: 1'b1, x: '0, y: '0, dc: '0};
		end
		if (state_q == acr_pkg::FR_ROOT && sq_done) begin
			row_q <= '{finished: 1'b0, x: x_next, y: y_q, dc: dc};
		end
	end

	assign push_row = row_q;

	acr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (sq_root),
		.exact    (sq_exact)
	);

endmodule

### rtl/core/acr_fifo.sv
// Two-entry queue of row descriptors between the front and back parts.
// Uses acr_pkg for the descriptor type and depth.
module acr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  acr_pkg::row_t push_row,
	output logic          full,
	input  logic          pop,
	output acr_pkg::row_t pop_row,
	output logic          empty
);

	acr_pkg::row_t                     mem_q [acr_pkg::FIFO_DEPTH];
	logic [acr_pkg::FIFO_PTR_BITS-1:0] wr_q;
	logic [acr_pkg::FIFO_PTR_BITS-1:0] rd_q;
	logic [acr_pkg::FIFO_CNT_BITS-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + acr_pkg::FIFO_PTR_BITS'(1);
			if (pop)  rd_q <= rd_q + acr_pkg::FIFO_PTR_BITS'(1);
			if (push && !pop)      cnt_q <= cnt_q + acr_pkg::FIFO_CNT_BITS'(1);
			else if (pop && !push) cnt_q <= cnt_q - acr_pkg::FIFO_CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_row;
	end

	assign pop_row = mem_q[rd_q];
	assign full    = (cnt_q == acr_pkg::FIFO_CNT_BITS'(acr_pkg::FIFO_DEPTH));
	assign empty   = (cnt_q == '0);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("row pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("row popped from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= acr_pkg::FIFO_CNT_BITS'(acr_pkg::FIFO_DEPTH))
		else $error("queue count beyond depth");

endmodule

### rtl/core/acr_back.sv
// Back part: takes row descriptors from the queue and emits the 24 pixels
// of a row, or one finished marker, through an output register. Uses acr_pkg.
module acr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  acr_pkg::cfg_t                       cfg,
	output logic                                pop,
	input  acr_pkg::row_t                       row,
	input  logic                                empty,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [acr_pkg::OUT_DATA_BITS-1:0]   out_data,
	output logic                                out_last,
	output logic                                out_finished
);

	logic                               have_q;
	acr_pkg::row_t                      cur_q;
	logic [acr_pkg::POINT_BITS-1:0]     pt_q;
	acr_pkg::nb_t                       nb_q;
	logic                               valid_q;
	logic                               last_q;
	logic                               fin_q;
	logic [acr_pkg::PIX_BITS-1:0]       px_q;
	logic [acr_pkg::PIX_BITS-1:0]       py_q;
	logic [acr_pkg::COLOR_BITS-1:0]     red_q;
	logic [acr_pkg::COLOR_BITS-1:0]     green_q;
	logic [acr_pkg::COLOR_BITS-1:0]     blue_q;

	logic                                          emit;
	logic                                          row_end;
	acr_pkg::point_t                               pnt;
	logic signed [acr_pkg::PIX_BITS-1:0]           xe;
	logic signed [acr_pkg::PIX_BITS-1:0]           xo;
	logic signed [acr_pkg::PIX_BITS-1:0]           xv;
	logic signed [acr_pkg::PIX_BITS-1:0]           yv;
	logic signed [acr_pkg::PIX_BITS-1:0]           cx;
	logic signed [acr_pkg::PIX_BITS-1:0]           cy;
	logic [acr_pkg::PIX_BITS-1:0]                  px;
	logic [acr_pkg::PIX_BITS-1:0]                  py;
	logic [acr_pkg::WEIGHT_BITS-1:0]               w;
	logic [acr_pkg::COLOR_BITS+acr_pkg::WEIGHT_BITS-1:0] prod_r;
	logic [acr_pkg::COLOR_BITS+acr_pkg::WEIGHT_BITS-1:0] prod_g;
	logic [acr_pkg::COLOR_BITS+acr_pkg::WEIGHT_BITS-1:0] prod_b;

	always_comb begin
		emit    = have_q && (!valid_q || out_ready);
		pop     = !have_q && !empty;
		row_end = cur_q.finished ||
			(pt_q == acr_pkg::POINT_BITS'(acr_pkg::POINTS - 1) && nb_q == acr_pkg::NB_OUTER);
		pnt = acr_pkg::point_lookup(pt_q);
		xe  = {{(acr_pkg::PIX_BITS-acr_pkg::POS_BITS){cur_q.x[acr_pkg::POS_BITS-1]}}, cur_q.x};
		yv  = {{(acr_pkg::PIX_BITS-acr_pkg::POS_BITS){1'b0}}, cur_q.y};
		cx  = {{(acr_pkg::PIX_BITS-acr_pkg::COORD_BITS){1'b0}}, cfg.centre_x};
		cy  = {{(acr_pkg::PIX_BITS-acr_pkg::COORD_BITS){1'b0}}, cfg.centre_y};
		case (nb_q)
			acr_pkg::NB_INNER: begin
				xo = xe - acr_pkg::PIX_BITS'(1);
				w  = {1'b0, cur_q.dc};
			end
			acr_pkg::NB_OUTER: begin
				xo = xe + acr_pkg::PIX_BITS'(1);
				w  = acr_pkg::WEIGHT_BITS'(1 << acr_pkg::FRACTION_BITS) - {1'b0, cur_q.dc};
			end
			default: begin
				xo = xe;
				w  = '0;
			end
		endcase
		xv = pnt.neg_x ? -xo : xo;
		if (pnt.neg_y) yv = -yv;
		px = pnt.swap ? yv + cx : xv + cx;
		py = pnt.swap ? xv + cy : yv + cy;
		prod_r = {{acr_pkg::WEIGHT_BITS{1'b0}}, cfg.red} *
			{{acr_pkg::COLOR_BITS{1'b0}}, w};
		prod_g = {{acr_pkg::WEIGHT_BITS{1'b0}}, cfg.green} *
			{{acr_pkg::COLOR_BITS{1'b0}}, w};
		prod_b = {{acr_pkg::WEIGHT_BITS{1'b0}}, cfg.blue} *
			{{acr_pkg::COLOR_BITS{1'b0}}, w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			valid_q <= 1'b0;
			pt_q    <= '0;
			nb_q    <= acr_pkg::NB_CENTRE;
		end else begin
			if (pop) begin
				have_q <= 1'b1;
				pt_q   <= '0;
				nb_q   <= acr_pkg::NB_CENTRE;
			end else if (emit) begin
				if (row_end) have_q <= 1'b0;
				case (nb_q)
					acr_pkg::NB_CENTRE: nb_q <= acr_pkg::NB_INNER;
					acr_pkg::NB_INNER:  nb_q <= acr_pkg::NB_OUTER;
					default: begin
						nb_q <= acr_pkg::NB_CENTRE;
						pt_q <= pt_q + acr_pkg::POINT_BITS'(1);
					end
				endcase
			end
			if (emit)           valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= row;
		if (emit) begin
			last_q <= row_end;
			fin_q  <= cur_q.finished;
			if (cur_q.finished) begin
				px_q    <= '0;
				py_q    <= '0;
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end else begin
				px_q <= px;
				py_q <= py;
				if (nb_q == acr_pkg::NB_CENTRE) begin
					red_q   <= cfg.red;
					green_q <= cfg.green;
					blue_q  <= cfg.blue;
				end else begin
					red_q   <= prod_r[acr_pkg::FRACTION_BITS +: acr_pkg::COLOR_BITS];
					green_q <= prod_g[acr_pkg::FRACTION_BITS +: acr_pkg::COLOR_BITS];
					blue_q  <= prod_b[acr_pkg::FRACTION_BITS +: acr_pkg::COLOR_BITS];
				end
			end
		end
	end

	assign out_valid    = valid_q;
	assign out_last     = last_q;
	assign out_finished = fin_q;
	assign out_data     = {{acr_pkg::OUT_PAD_BITS{1'b0}}, blue_q, green_q, red_q, py_q, px_q};

	a_fin_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && fin_q |-> last_q) else $error("finished marker not last of its request");
	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && fin_q |-> (px_q == '0 && py_q == '0 && red_q == '0))
		else $error("finished marker carries pixel data");
	a_fin_first: assert property (@(posedge clk) disable iff (!arst_n)
		have_q && cur_q.finished |-> (pt_q == '0 && nb_q == acr_pkg::NB_CENTRE))
		else $error("finished row advanced past its single transaction");

endmodule

### rtl/core/antialiased_circle_rasterizer.sv
// Top level of the anti-aliased circle rasterizer: configuration registers,
// front part, row queue and back part. Uses acr_pkg, acr_front, acr_fifo, acr_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//   input    | s_tvalid/s_tready   | s_tdata: restart
//   output   | m_tvalid/m_tready   | m_tdata: pixel x, y, red, green, blue;
//            |                     | m_tlast: row last; m_tuser: finished
//
// The front part steps from one accepted request to the next through acceptance, a check,
// the two squares, the subtraction, 19 square root steps, the step that sees the root and the push.
// A request that finds the octant done goes from the check straight to the push.
// The back part loads a row from the queue and sends one pixel a cycle while the output
// is ready; a full queue holds the front part at its push and keeps s_tready low.
// Reset clears all control state; no clearing pass is needed. cfg_ready is always high.
module antialiased_circle_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [acr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [acr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [acr_pkg::IN_DATA_BITS-1:0]    s_tdata,   // [0] restart
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [acr_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // pixel_x, pixel_y, red, green, blue
	output logic                                m_tlast,
	output logic                                m_tuser    // [0] finished
);

	acr_pkg::cfg_t cfg_q;
	logic          push;
	acr_pkg::row_t push_row;
	logic          full;
	logic          pop;
	acr_pkg::row_t pop_row;
	logic          empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_x <= '0;
			cfg_q.centre_y <= '0;
			cfg_q.radius   <= '0;
			cfg_q.red      <= '1;
			cfg_q.green    <= '1;
			cfg_q.blue     <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				acr_pkg::CFG_CENTRE_X:    cfg_q.centre_x <= cfg_data[acr_pkg::COORD_BITS-1:0];
				acr_pkg::CFG_CENTRE_Y:    cfg_q.centre_y <= cfg_data[acr_pkg::COORD_BITS-1:0];
				acr_pkg::CFG_RADIUS:      cfg_q.radius   <= cfg_data[acr_pkg::RAD_BITS-1:0];
				acr_pkg::CFG_COLOR_RED:   cfg_q.red      <= cfg_data[acr_pkg::COLOR_BITS-1:0];
				acr_pkg::CFG_COLOR_GREEN: cfg_q.green    <= cfg_data[acr_pkg::COLOR_BITS-1:0];
				acr_pkg::CFG_COLOR_BLUE:  cfg_q.blue     <= cfg_data[acr_pkg::COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	acr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.restart  (s_tdata[0]),
		.radius   (cfg_q.radius),
		.push     (push),
		.push_row (push_row),
		.full     (full)
	);

	acr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_row (push_row),
		.full     (full),
		.pop      (pop),
		.pop_row  (pop_row),
		.empty    (empty)
	);

	acr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop          (pop),
		.row          (pop_row),
		.empty        (empty),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (m_tdata),
		.out_last     (m_tlast),
		.out_finished (m_tuser)
	);

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for antialiased_circle_rasterizer: drives row requests and register writes,
// predicts every pixel transaction with its own octant walker and compares them in order.
// Depends on acr_pkg and the rasterizer RTL only.
module testbench;
	import acr_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int TAIL_CYCLES = 60;
	localparam int RANDOM_ITEMS = 88;
	localparam int ONE_WEIGHT = 1 << FRACTION_BITS;
	localparam int Y_LSB = PIX_BITS;
	localparam int RED_LSB = 2 * PIX_BITS;
	localparam int GREEN_LSB = RED_LSB + COLOR_BITS;
	localparam int BLUE_LSB = GREEN_LSB + COLOR_BITS;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [7:0] MIRROR_NEG_X = 8'b1110_0100;
	localparam logic [7:0] MIRROR_NEG_Y = 8'b1101_1000;
	localparam logic [7:0] MIRROR_SWAP  = 8'b0110_1010;

	typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

	typedef struct packed {
		logic [PIX_BITS-1:0]   x;
		logic [PIX_BITS-1:0]   y;
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
		logic                  last;
		logic                  fin;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	cfg_t shadow_cfg = '{centre_x: '0, centre_y: '0, radius: '0,
		red: 8'hFF, green: 8'hFF, blue: 8'hFF};
	int oct_x = 0;
	int oct_y = 0;
	int unsigned prev_dc = 0;
	logic circle_running = 1'b0;

	pixel_t pending_pixels[$];
	int failures = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	logic gaps_on = 1'b0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int hold_request = 0;
	int hold_left = 0;
	int stall_phase = 0;

	antialiased_circle_rasterizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned acc, probe, rest;
		acc = 0;
		rest = v;
		probe = 64'd1 << 62;
		while (probe > rest)
			probe >>= 2;
		while (probe != 0) begin
			if (rest >= acc + probe) begin
				rest -= acc + probe;
				acc = (acc >> 1) + probe;
			end else begin
				acc >>= 1;
			end
			probe >>= 2;
		end
		return acc;
	endfunction

	// Fraction by which sqrt(r*r - y*y) falls short of its ceiling, truncated.
	function automatic int unsigned ceil_gap(input int unsigned r, input int unsigned y);
		longint unsigned v, scaled, whole, fine;
		if (y > r)
			return 0;
		v = longint'(r) * r - longint'(y) * y;
		whole = floor_root(v);
		if (whole * whole == v)
			return 0;
		whole += 1;
		scaled = v << (2 * FRACTION_BITS);
		fine = floor_root(scaled);
		if (fine * fine != scaled)
			fine += 1;
		return int'((whole << FRACTION_BITS) - fine);
	endfunction

	function automatic logic [COLOR_BITS-1:0] shade(input logic [COLOR_BITS-1:0] c,
			input int unsigned w);
		return COLOR_BITS'((int'(c) * w) >> FRACTION_BITS);
	endfunction

	task automatic trace_row(input logic restart);
		pixel_t item;
		int unsigned dc, wgt;
		int k, j, sx, sy, xv, yv, cx, cy, px, py;
		logic full;
		if (restart) begin
			oct_x = int'(shadow_cfg.radius);
			oct_y = 0;
			prev_dc = 0;
			circle_running = 1'b1;
		end
		if (!circle_running || oct_x < oct_y) begin
			circle_running = 1'b0;
			item = '0;
			item.last = 1'b1;
			item.fin = 1'b1;
			pending_pixels.push_back(item);
			return;
		end
		dc = ceil_gap(shadow_cfg.radius, oct_y);
		if (dc <= prev_dc)
			oct_x--;
		cx = int'(shadow_cfg.centre_x);
		cy = int'(shadow_cfg.centre_y);
		for (k = 0; k < POINTS; k++) begin
			sx = MIRROR_NEG_X[k] ? -1 : 1;
			sy = MIRROR_NEG_Y[k] ? -1 : 1;
			yv = sy * oct_y;
			for (j = 0; j < 3; j++) begin
				full = 1'b0;
				wgt = 0;
				xv = sx * oct_x;
				case (nb_t'(j))
					NB_CENTRE: full = 1'b1;
					NB_INNER: begin
						xv = xv - sx;
						wgt = dc;
					end
					default: begin
						xv = xv + sx;
						wgt = ONE_WEIGHT - dc;
					end
				endcase
				px = MIRROR_SWAP[k] ? yv + cx : xv + cx;
				py = MIRROR_SWAP[k] ? xv + cy : yv + cy;
				item.x = px[PIX_BITS-1:0];
				item.y = py[PIX_BITS-1:0];
				item.red = full ? shadow_cfg.red : shade(shadow_cfg.red, wgt);
				item.green = full ? shadow_cfg.green : shade(shadow_cfg.green, wgt);
				item.blue = full ? shadow_cfg.blue : shade(shadow_cfg.blue, wgt);
				item.last = (k == POINTS - 1) && (j == 2);
				item.fin = 1'b0;
				pending_pixels.push_back(item);
			end
		end
		prev_dc = dc;
		oct_y++;
	endtask

	task automatic send_request(input logic restart);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_BITS - 1){1'b0}}, restart};
		do @(posedge clk); while (!s_tready);
		trace_row(restart);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CENTRE_X: shadow_cfg.centre_x = data;
			CFG_CENTRE_Y: shadow_cfg.centre_y = data;
			CFG_RADIUS: shadow_cfg.radius = data[RAD_BITS-1:0];
			CFG_COLOR_RED: shadow_cfg.red = data[COLOR_BITS-1:0];
			CFG_COLOR_GREEN: shadow_cfg.green = data[COLOR_BITS-1:0];
			CFG_COLOR_BLUE: shadow_cfg.blue = data[COLOR_BITS-1:0];
			default: ;
		endcase
	endtask

	// Only called once every expected pixel has arrived.
	task automatic load_circle(input logic [CFG_DATA_BITS-1:0] cx, input logic [CFG_DATA_BITS-1:0] cy,
			input logic [CFG_DATA_BITS-1:0] r, input logic [CFG_DATA_BITS-1:0] red,
			input logic [CFG_DATA_BITS-1:0] green, input logic [CFG_DATA_BITS-1:0] blue,
			input logic spares);
		if (spares)
			write_reg(CFG_SPARE_LO, CFG_DATA_BITS'($urandom));
		write_reg(CFG_CENTRE_X, cx);
		write_reg(CFG_CENTRE_Y, cy);
		write_reg(CFG_RADIUS, r);
		write_reg(CFG_COLOR_RED, red);
		write_reg(CFG_COLOR_GREEN, green);
		write_reg(CFG_COLOR_BLUE, blue);
		if (spares)
			write_reg(CFG_SPARE_HI, CFG_DATA_BITS'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic test_after_reset();
		ready_mode = READY_ALWAYS;
		gaps_on = 1'b0;
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		drain_results();
	endtask

	task automatic test_extreme_config();
		ready_mode = READY_RANDOM;
		load_circle(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'hF80, 1'b1);
		send_request(1'b1);
		repeat (3) send_request(1'b0);
		drain_results();
		load_circle(12'h000, 12'h000, 12'h7FF, 12'h000, 12'h0FF, 12'h001, 1'b0);
		send_request(1'b1);
		repeat (2) send_request(1'b0);
		drain_results();
	endtask

	task automatic test_whole_octant();
		ready_mode = READY_PATTERN;
		gaps_on = 1'b1;
		load_circle(12'd100, 12'd200, 12'd5, 12'd200, 12'd100, 12'd50, 1'b0);
		send_request(1'b1);
		while (circle_running)
			send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		drain_results();
	endtask

	task automatic test_backpressure();
		ready_mode = READY_RANDOM;
		gaps_on = 1'b0;
		load_circle(12'd2000, 12'd1000, 12'd30, 12'd90, 12'd180, 12'd255, 1'b0);
		hold_request = 200;
		send_request(1'b1);
		repeat (11) send_request(1'b0);
		drain_results();
	endtask

	task automatic test_random_circles();
		int sent, rows, row_cap, pick;
		logic [CFG_DATA_BITS-1:0] r;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_results();
			pick = $urandom_range(0, 9);
			if (pick < 7)
				r = $urandom_range(0, 12);
			else if (pick < 9)
				r = $urandom_range(13, 60);
			else
				r = $urandom_range(61, 2047);
			r[RAD_BITS] = $urandom_range(0, 1);
			load_circle(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom), r,
				CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
				CFG_DATA_BITS'($urandom), $urandom_range(0, 3) == 0);
			ready_mode = ready_mode_t'($urandom_range(0, 2));
			gaps_on = $urandom_range(0, 2) != 0;
			row_cap = $urandom_range(3, 30);
			rows = 0;
			send_request(1'b1);
			sent++;
			while (circle_running && rows < row_cap && sent < RANDOM_ITEMS) begin
				send_request($urandom_range(0, 19) == 0);
				rows++;
				sent++;
			end
			if ($urandom_range(0, 3) == 0) begin
				send_request(1'b0);
				sent++;
			end
		end
		drain_results();
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		stall_phase = (stall_phase + 1) % 7;
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (ready_mode)
				READY_ALWAYS: m_tready <= 1'b1;
				READY_RANDOM: m_tready <= $urandom_range(0, 3) != 0;
				default: m_tready <= stall_phase >= 3;
			endcase
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("output transaction with nothing expected: tdata %h", m_tdata);
				failures++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_x", want.x, m_tdata[0 +: PIX_BITS]);
				check_field("pixel_y", want.y, m_tdata[Y_LSB +: PIX_BITS]);
				check_field("pixel_red", want.red, m_tdata[RED_LSB +: COLOR_BITS]);
				check_field("pixel_green", want.green, m_tdata[GREEN_LSB +: COLOR_BITS]);
				check_field("pixel_blue", want.blue, m_tdata[BLUE_LSB +: COLOR_BITS]);
				check_field("padding", 0, m_tdata[OUT_DATA_BITS-1 -: OUT_PAD_BITS]);
				check_field("row_last", want.last, m_tlast);
				check_field("finished", want.fin, m_tuser);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_extreme_config();
		test_whole_octant();
		test_backpressure();
		test_random_circles();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$error("%0d expected pixels never arrived", pending_pixels.size());
			failures++;
		end
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/acr_pkg.sv
rtl/core/acr_sqrt.sv
rtl/core/acr_front.sv
rtl/core/acr_fifo.sv
rtl/core/acr_back.sv
rtl/core/antialiased_circle_rasterizer.sv
bench/testbench.sv
